### rtl/conv5x5_relu_stream_assert.svh
// Assertion macros shared by the checker of the 5x5 convolution block.
// Included by bare name; holds only macro definitions.
`ifndef CONV5X5_RELU_STREAM_ASSERT_SVH
`define CONV5X5_RELU_STREAM_ASSERT_SVH

// implication checked on every clock edge outside reset
`define C55_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication whose consequent is checked in the next cycle
`define C55_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/c55_pkg.sv
// Package for the 5x5 convolution block: sizes, action codes, item types.
// No dependencies.
package c55_pkg;
	localparam int IMG_SIDE    = 28;
	localparam int NUM_FILTERS = 30;
	localparam int KERNEL_SIDE = 5;
	localparam int TAPS        = KERNEL_SIDE * KERNEL_SIDE;
	localparam int ROW_DEPTH   = KERNEL_SIDE * IMG_SIDE;
	localparam int W_DEPTH     = NUM_FILTERS * TAPS;
	localparam int RA_W        = $clog2(ROW_DEPTH);
	localparam int WA_W        = $clog2(W_DEPTH);
	localparam int FA_W        = $clog2(NUM_FILTERS);
	localparam int TA_W        = $clog2(TAPS);
	localparam int POS_W       = $clog2(IMG_SIDE);
	localparam int KR_W        = $clog2(KERNEL_SIDE);
	localparam int ACC_W       = 48;

	localparam logic [1:0] ACT_PIXEL  = 2'd0;
	localparam logic [1:0] ACT_WEIGHT = 2'd1;
	localparam logic [1:0] ACT_BIAS   = 2'd2;

	typedef struct packed {
		logic [1:0]         action;
		logic [4:0]         filter_sel;
		logic [4:0]         tap_sel;
		logic [7:0]         pixel;
		logic signed [15:0] weight;
		logic signed [31:0] bias;
	} in_item_t;

	typedef struct packed {
		logic [4:0]  out_filter;
		logic [4:0]  out_row;
		logic [4:0]  out_col;
		logic [30:0] activation;
		logic        last;
	} out_item_t;

	// window job handed from control to the datapath
	typedef struct packed {
		logic             start;
		logic [POS_W-1:0] r0;
		logic [POS_W-1:0] c0;
		logic [KR_W-1:0]  slot0;
	} job_t;
endpackage

### rtl/c55_if.sv
// Valid/ready stream interface carrying one payload item.
// Depends on nothing; payload type is a parameter.
interface c55_stream_if #(parameter type T = logic) (input logic clk);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/conv5x5_relu_stream.sv
// Top level of the streaming 5x5 convolution with bias and ReLU.
// Depends on c55_pkg, c55_stream_if, c55_ctrl, c55_mac.
// Weight and bias writes are accepted as single items. A pixel that closes a
// window blocks input during window gather from the row memory and hand-off,
// then the MAC sweeps one weight per cycle from the weight memory, 25 taps
// per filter, then finishes the sum and presents the result; after each
// filter's last tap the sweep holds until that result is taken. Input stays
// closed until all filters are done. Other pixels do not block input. No clearing pass after reset.
module conv5x5_relu_stream import c55_pkg::*; (
	input logic clk,
	input logic arst_n,
	c55_stream_if.sink   in_ch,
	c55_stream_if.source out_ch
);
	logic              wwe, bwe, busy;
	logic [WA_W-1:0]   waddr;
	logic [FA_W-1:0]   baddr;
	logic [TAPS*8-1:0] window;
	job_t              job;
	in_item_t          item;

	assign item = in_ch.data;

	c55_ctrl u_ctrl (
		.clk, .arst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready), .item,
		.mac_busy(busy), .wwe, .waddr, .bwe, .baddr, .window, .job
	);

	c55_mac u_mac (
		.clk, .arst_n, .wwe, .waddr, .wdata(item.weight), .bwe, .baddr,
		.bdata(item.bias), .window, .job, .busy,
		.res_valid(out_ch.valid), .res(out_ch.data), .res_ready(out_ch.ready)
	);
endmodule

### rtl/c55_mac.sv
// Datapath: weight and bias memories, window register, per-filter MAC sweep.
// Depends on c55_pkg.
module c55_mac import c55_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wwe,
	input  logic [WA_W-1:0]      waddr,
	input  logic signed [15:0]   wdata,
	input  logic                 bwe,
	input  logic [FA_W-1:0]      baddr,
	input  logic signed [31:0]   bdata,
	input  logic [TAPS*8-1:0]    window,
	input  job_t                 job,
	output logic                 busy,
	output logic                 res_valid,
	output out_item_t            res,
	input  logic                 res_ready
);
	logic signed [15:0] wmem [W_DEPTH];
	logic signed [31:0] bmem [NUM_FILTERS];
	logic signed [15:0] wrd_s1;
	logic signed [31:0] brd_s1;
	logic [TAPS*8-1:0]  win_q;
	logic [FA_W-1:0]    f_q, f_s1;
	logic [TA_W-1:0]    t_q, t_s1;
	logic               run_q, v_s1, last_s1;
	logic [POS_W-1:0]   r0_q, c0_q;
	logic signed [ACC_W-1:0] acc_q;
	logic               hold_q;
	logic [7:0]         pix;
	logic signed [24:0] prod;
	logic signed [ACC_W-1:0] accn;
	logic               adv;

	// one weight per cycle; hold sweep while a finished result is not taken
	assign adv  = run_q && !hold_q;
	assign busy = run_q || v_s1 || hold_q;

	always_ff @(posedge clk) begin
		if (wwe) wmem[waddr] <= wdata;
		if (bwe) bmem[baddr] <= bdata;
		wrd_s1 <= wmem[WA_W'(f_q) * WA_W'(TAPS) + WA_W'(t_q)];
		brd_s1 <= bmem[f_q];
		if (job.start) win_q <= window;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0; v_s1 <= 1'b0; f_q <= '0; t_q <= '0;
			f_s1 <= '0; t_s1 <= '0; last_s1 <= 1'b0;
		end else begin
			v_s1 <= adv;
			if (adv) begin
				f_s1 <= f_q; t_s1 <= t_q;
				last_s1 <= (t_q == TA_W'(TAPS-1));
			end
			if (job.start) begin
				run_q <= 1'b1; f_q <= '0; t_q <= '0;
				r0_q <= job.r0; c0_q <= job.c0;
			end else if (adv) begin
				if (t_q == TA_W'(TAPS-1)) begin
					t_q <= '0;
					if (f_q == FA_W'(NUM_FILTERS-1)) run_q <= 1'b0;
					else f_q <= f_q + 1'b1;
				end else t_q <= t_q + 1'b1;
			end
		end
	end

	assign pix  = win_q[t_s1*8 +: 8];
	assign prod = $signed({1'b0, pix}) * wrd_s1;
	always_comb begin
		accn = (t_s1 == '0) ? ACC_W'(brd_s1) : acc_q;
		accn = accn + ACC_W'(prod);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 1'b0; res_valid <= 1'b0;
		end else begin
			if (res_valid && res_ready) res_valid <= 1'b0;
			if (v_s1) acc_q <= accn;
			// stop issue after final tap of a filter until result leaves
			if (adv && t_q == TA_W'(TAPS-1)) hold_q <= 1'b1;
			if (v_s1 && last_s1) begin
				res_valid <= 1'b1;
				res.out_filter <= 5'(f_s1);
				res.out_row    <= 5'(r0_q);
				res.out_col    <= 5'(c0_q);
				res.last       <= (f_s1 == FA_W'(NUM_FILTERS-1));
				if (accn[ACC_W-1] || accn == '0) res.activation <= '0;
				else if (accn > ACC_W'(32'h7FFF_FFFF)) res.activation <= 31'h7FFF_FFFF;
				else res.activation <= accn[30:0];
			end
			if (hold_q && !v_s1 && (!res_valid || res_ready)) hold_q <= 1'b0;
		end
	end
endmodule

### rtl/c55_ctrl.sv
// Control: raster position, row memory and window gather sequencer.
// Depends on c55_pkg.
module c55_ctrl import c55_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  in_item_t          item,
	input  logic              mac_busy,
	output logic              wwe,
	output logic [WA_W-1:0]   waddr,
	output logic              bwe,
	output logic [FA_W-1:0]   baddr,
	output logic [TAPS*8-1:0] window,
	output job_t              job
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_GATH = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;

	logic [7:0]       rmem [ROW_DEPTH];
	logic [7:0]       rd_s1;
	logic [1:0]       st_q;
	logic [POS_W-1:0] row_q, col_q, r0_q, c0_q;
	logic [KR_W-1:0]  slot_q, gx_q, gy_q, gx_s1, gy_s1;
	logic             gv_s1;
	logic [KR_W-1:0]  rs;
	logic [RA_W-1:0]  raddr;
	logic             acc_in, pix_in, fire;
	logic [TA_W-1:0]  wtap;

	// hand-off cycle: MAC has not picked up the job yet, keep input closed
	assign in_ready = (st_q == ST_IDLE) && !mac_busy && !job.start;
	assign acc_in   = in_valid && in_ready;
	assign pix_in   = acc_in && item.action == ACT_PIXEL;
	assign fire     = pix_in && row_q >= POS_W'(KERNEL_SIDE-1) && col_q >= POS_W'(KERNEL_SIDE-1);

	assign wwe   = acc_in && item.action == ACT_WEIGHT && item.filter_sel < 5'(NUM_FILTERS)
	               && item.tap_sel < 5'(TAPS);
	assign waddr = WA_W'(item.filter_sel) * WA_W'(TAPS) + WA_W'(item.tap_sel);
	assign bwe   = acc_in && item.action == ACT_BIAS && item.filter_sel < 5'(NUM_FILTERS);
	assign baddr = FA_W'(item.filter_sel);
	assign wtap  = TA_W'(gx_s1) * TA_W'(KERNEL_SIDE) + TA_W'(gy_s1);

	// window row gx lives in slot (top slot + gx) mod K
	always_comb begin
		rs = (32'(slot_q) + 32'(gx_q) >= KERNEL_SIDE) ?
			KR_W'(32'(slot_q) + 32'(gx_q) - KERNEL_SIDE) : slot_q + gx_q;
	end
	assign raddr = RA_W'(rs) * RA_W'(IMG_SIDE) + RA_W'(c0_q) + RA_W'(gy_q);

	logic [KR_W-1:0] wslot_q;
	always_ff @(posedge clk) begin
		if (pix_in) rmem[RA_W'(wslot_q) * RA_W'(IMG_SIDE) + RA_W'(col_q)] <= item.pixel;
		rd_s1 <= rmem[raddr];
		if (gv_s1) window[wtap*8 +: 8] <= rd_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; row_q <= '0; col_q <= '0; wslot_q <= '0;
			gv_s1 <= 1'b0; gx_q <= '0; gy_q <= '0; slot_q <= '0;
			job <= '0;
		end else begin
			job.start <= 1'b0;
			gv_s1 <= (st_q == ST_GATH);
			gx_s1 <= gx_q; gy_s1 <= gy_q;
			if (pix_in) begin
				if (col_q == POS_W'(IMG_SIDE-1)) begin
					col_q <= '0;
					wslot_q <= (wslot_q == KR_W'(KERNEL_SIDE-1)) ? '0 : wslot_q + 1'b1;
					if (row_q == POS_W'(IMG_SIDE-1)) begin
						row_q <= '0; wslot_q <= '0;
					end else row_q <= row_q + 1'b1;
				end else col_q <= col_q + 1'b1;
			end
			case (st_q)
				ST_IDLE: begin
					if (fire) begin
						st_q <= ST_GATH; gx_q <= '0; gy_q <= '0;
						r0_q <= row_q - POS_W'(KERNEL_SIDE-1);
						c0_q <= col_q - POS_W'(KERNEL_SIDE-1);
						// oldest row slot follows the one just written
						slot_q <= (wslot_q == KR_W'(KERNEL_SIDE-1)) ? '0 : wslot_q + 1'b1;
					end
				end
				ST_GATH: begin
					if (gy_q == KR_W'(KERNEL_SIDE-1)) begin
						gy_q <= '0;
						if (gx_q == KR_W'(KERNEL_SIDE-1)) st_q <= ST_WAIT;
						else gx_q <= gx_q + 1'b1;
					end else gy_q <= gy_q + 1'b1;
				end
				ST_WAIT: begin
					if (!gv_s1) begin
						st_q <= ST_IDLE;
						job.start <= 1'b1; job.r0 <= r0_q; job.c0 <= c0_q;
						job.slot0 <= slot_q;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule

### rtl/c55_checker.sv
// Port-level checker for conv5x5_relu_stream, bound to the top level.
// Depends on c55_pkg and conv5x5_relu_stream_assert.svh.
`include "conv5x5_relu_stream_assert.svh"
module c55_checker import c55_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data
);
	`C55_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result dropped while stalled")
	`C55_ASSERT_IMPL(a_busy, clk, arst_n, out_valid, !in_ready, "input taken during result sweep")
	`C55_ASSERT_IMPL(a_last, clk, arst_n, out_valid && out_data.last, out_data.out_filter == 5'(NUM_FILTERS-1), "last flag on wrong filter")
	`C55_ASSERT_IMPL(a_pos, clk, arst_n, out_valid, out_data.out_row <= 5'(IMG_SIDE-KERNEL_SIDE) && out_data.out_col <= 5'(IMG_SIDE-KERNEL_SIDE), "window position out of map")
endmodule

bind conv5x5_relu_stream c55_checker u_chk (
	.clk, .arst_n, .in_ready(in_ch.ready), .out_valid(out_ch.valid),
	.out_ready(out_ch.ready), .out_data(out_ch.data)
);

### verif/c55_conv_checker.sv
`timescale 1ns / 100ps
// Checker for the 5x5 convolution block: watches both item channels,
// predicts each filter result and compares. Depends on c55_pkg.
module c55_conv_checker import c55_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input in_item_t  in_data,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data,
	output int       fails,
	output int       pending
);
	logic [7:0]         pix_rows [ROW_DEPTH];
	logic signed [15:0] coef [W_DEPTH];
	logic signed [31:0] offs [NUM_FILTERS];
	int                 cur_row, cur_col;
	out_item_t          want_q [$];

	assign pending = want_q.size();

	// apply one accepted input item to the shadow state, queue its results
	task automatic conv_predict(input in_item_t it);
		int        r0, c0, f, x, y;
		longint    acc;
		out_item_t o;
		begin
			if (it.action == ACT_WEIGHT) begin
				if (it.filter_sel < NUM_FILTERS && it.tap_sel < TAPS)
					coef[it.filter_sel * TAPS + it.tap_sel] = it.weight;
			end else if (it.action == ACT_BIAS) begin
				if (it.filter_sel < NUM_FILTERS)
					offs[it.filter_sel] = it.bias;
			end else if (it.action == ACT_PIXEL) begin
				pix_rows[(cur_row % KERNEL_SIDE) * IMG_SIDE + cur_col] = it.pixel;
				if (cur_row >= KERNEL_SIDE - 1 && cur_col >= KERNEL_SIDE - 1) begin
					r0 = cur_row - (KERNEL_SIDE - 1);
					c0 = cur_col - (KERNEL_SIDE - 1);
					for (f = 0; f < NUM_FILTERS; f++) begin
						acc = longint'(offs[f]);
						for (x = 0; x < KERNEL_SIDE; x++)
							for (y = 0; y < KERNEL_SIDE; y++)
								acc += longint'({1'b0, pix_rows[((r0 + x) % KERNEL_SIDE)
									* IMG_SIDE + c0 + y]})
									* longint'(coef[f * TAPS + x * KERNEL_SIDE + y]);
						if (acc < 0)
							acc = 0;
						if (acc > 64'sd2147483647)
							acc = 64'sd2147483647;
						o.out_filter = f[4:0];
						o.out_row    = r0[4:0];
						o.out_col    = c0[4:0];
						o.activation = acc[30:0];
						o.last       = (f == NUM_FILTERS - 1);
						want_q.push_back(o);
					end
				end
				cur_col++;
				if (cur_col >= IMG_SIDE) begin
					cur_col = 0;
					cur_row = (cur_row + 1 >= IMG_SIDE) ? 0 : cur_row + 1;
				end
			end
		end
	endtask

	initial begin
		fails   = 0;
		cur_row = 0;
		cur_col = 0;
	end

	always @(posedge clk) begin
		out_item_t w;
		if (arst_n) begin
			if (in_valid && in_ready)
				conv_predict(in_data);
			if (out_valid && out_ready) begin
				if (want_q.size() == 0) begin
					fails++;
					$display("%0t: unexpected result %h", $time, out_data);
				end else begin
					w = want_q.pop_front();
					if (w.out_filter !== out_data.out_filter || w.out_row !== out_data.out_row
						|| w.out_col !== out_data.out_col
						|| w.activation !== out_data.activation || w.last !== out_data.last) begin
						fails++;
						$display("%0t: expected f%0d r%0d c%0d act %0d last %0b, got f%0d r%0d c%0d act %0d last %0b",
							$time, w.out_filter, w.out_row, w.out_col, w.activation, w.last,
							out_data.out_filter, out_data.out_row, out_data.out_col,
							out_data.activation, out_data.last);
					end
				end
			end
		end
	end
endmodule

### verif/tb_conv5x5_relu_stream.sv
`timescale 1ns / 100ps
// Testbench top for the 5x5 convolution block: clock, reset, item stimulus
// and verdict. Depends on c55_pkg, c55_stream_if, c55_conv_checker.
module tb_conv5x5_relu_stream;
	import c55_pkg::*;

	localparam logic [1:0] ACT_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n;
	int   fails, pending;
	bit   send_burst, recv_burst;

	c55_stream_if #(.T(in_item_t))  in_if (clk);
	c55_stream_if #(.T(out_item_t)) out_if (clk);

	conv5x5_relu_stream DUT (.clk(clk), .arst_n(arst_n), .in_ch(in_if), .out_ch(out_if));

	c55_conv_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_if.valid), .in_ready(in_if.ready), .in_data(in_if.data),
		.out_valid(out_if.valid), .out_ready(out_if.ready), .out_data(out_if.data),
		.fails(fails), .pending(pending)
	);

	always #2 clk = ~clk;

	initial begin
		#20_000_000;
		$display("Mismatches found");
		$finish;
	end

	function automatic in_item_t noise_item();
		in_item_t it;
		it.action     = 2'($urandom);
		it.filter_sel = 5'($urandom);
		it.tap_sel    = 5'($urandom);
		it.pixel      = 8'($urandom);
		it.weight     = 16'($urandom);
		it.bias       = $urandom;
		return it;
	endfunction

	task automatic send_item(input in_item_t it);
		int gap;
		begin
			gap = send_burst ? 0 : $urandom_range(0, 17);
			if (gap > 0) begin
				in_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			in_if.valid <= 1'b1;
			in_if.data  <= it;
			do @(posedge clk); while (!in_if.ready);
		end
	endtask

	task automatic put_weight(input int f, input int t, input logic signed [15:0] w);
		in_item_t it;
		begin
			it = noise_item();
			it.action = ACT_WEIGHT;
			it.filter_sel = 5'(f);
			it.tap_sel = 5'(t);
			it.weight = w;
			send_item(it);
		end
	endtask

	task automatic put_bias(input int f, input logic signed [31:0] b);
		in_item_t it;
		begin
			it = noise_item();
			it.action = ACT_BIAS;
			it.filter_sel = 5'(f);
			it.bias = b;
			send_item(it);
		end
	endtask

	task automatic put_pixel(input logic [7:0] p);
		in_item_t it;
		begin
			it = noise_item();
			it.action = ACT_PIXEL;
			it.pixel = p;
			send_item(it);
		end
	endtask

	function automatic logic signed [31:0] some_bias();
		case ($urandom_range(0, 5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return $urandom;
			default: return $signed($urandom_range(0, 1 << 25)) - (1 << 24);
		endcase
	endfunction

	// result side: random stall before each result, with bursts of none
	initial begin
		int stall;
		out_if.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 39) == 0)
				recv_burst = !recv_burst;
			stall = recv_burst ? 0 : $urandom_range(0, 17);
			if (stall > 0) begin
				out_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_if.ready <= 1'b1;
			do @(posedge clk); while (!out_if.valid);
		end
	end

	initial begin
		in_item_t it;
		int       f, t, n, waited;
		arst_n = 1'b0;
		in_if.valid <= 1'b0;
		in_if.data  <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every weight and bias must be loaded before the first window closes
		for (f = 0; f < NUM_FILTERS; f++) begin
			for (t = 0; t < TAPS; t++) begin
				if ($urandom_range(0, 3) == 0)
					put_weight(f, t, 16'($urandom));
				else
					put_weight(f, t, 16'($signed($urandom_range(0, 8191)) - 4096));
			end
			put_bias(f, some_bias());
		end

		// directed: field extremes, saturation both ways, ignored items
		put_weight(0, 0, 16'sh7fff);
		put_weight(0, 24, 16'sh7fff);
		put_weight(1, 0, 16'sh8000);
		put_weight(NUM_FILTERS - 1, 12, 16'sh8000);
		put_bias(0, 32'sh7fffffff);
		put_bias(1, 32'sh80000000);
		put_bias(NUM_FILTERS - 1, 32'sh0);
		put_weight(30, 3, 16'sh1234);
		put_weight(31, 0, 16'sh7fff);
		put_weight(2, 25, 16'sh8000);
		put_weight(2, 31, 16'sh7fff);
		put_bias(30, 32'sh7fffffff);
		put_bias(31, 32'sh80000000);
		it = noise_item();
		it.action = ACT_UNUSED;
		send_item(it);
		put_pixel(8'd0);
		put_pixel(8'd255);
		for (n = 0; n < 8; n++)
			put_pixel(n[0] ? 8'd255 : 8'd0);

		for (n = 0; n < 470; n++) begin
			if ($urandom_range(0, 29) == 0)
				send_burst = !send_burst;
			if (n == 300) begin
				// hold off until the block has drained completely
				in_if.valid <= 1'b0;
				@(posedge clk);
				while (pending != 0)
					@(posedge clk);
			end
			case ($urandom_range(0, 19))
				0: put_weight($urandom_range(0, NUM_FILTERS - 1),
					$urandom_range(0, TAPS - 1), 16'($urandom));
				1: put_bias($urandom_range(0, NUM_FILTERS - 1), some_bias());
				2: begin
					it = noise_item();
					if (it.action == ACT_PIXEL)
						it.action = ACT_UNUSED;
					if (it.action == ACT_WEIGHT && it.filter_sel < NUM_FILTERS
						&& it.tap_sel < TAPS)
						it.tap_sel = 5'($urandom_range(TAPS, 31));
					if (it.action == ACT_BIAS && it.filter_sel < NUM_FILTERS)
						it.filter_sel = 5'($urandom_range(NUM_FILTERS, 31));
					send_item(it);
				end
				default: put_pixel(8'($urandom));
			endcase
		end
		in_if.valid <= 1'b0;

		waited = 0;
		while (pending != 0 && waited < 200000) begin
			@(posedge clk);
			waited++;
		end
		repeat (1000) @(posedge clk);
		if (fails == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
